// File: hdl/dpwe_pkg.sv
`default_nettype none

package dpwe_pkg;

    // Block geometry
    localparam int unsigned NUM_PORT_LANES = 4;
    localparam int unsigned LANES          = 4;
    localparam int unsigned FRAME_BITS     = 16;
    localparam int unsigned SLOTS          = 18;
    localparam int unsigned SLOT_W         = $clog2(SLOTS);

    // Timing
    localparam int unsigned BIT_RATE_HZ = 300000;
    localparam int unsigned RATE_W      = $clog2(BIT_RATE_HZ + 1);
    localparam int unsigned CLOCK_W     = 32;
    localparam int unsigned DUTY_W      = 16;
    localparam int unsigned PERIOD_MAX  = 65535;
    localparam int unsigned DUTY_DEN    = 8;
    localparam int unsigned DEN_SHIFT   = $clog2(DUTY_DEN);
    localparam int unsigned ZERO_NUM    = 3;
    localparam int unsigned ONE_NUM     = 6;

    // Reciprocal of the bit rate, rounded up, scaled by 2^32. For any clock
    // that is an exact multiple of the rate, (clock * RECIP) >> 32 is exact.
    localparam longint unsigned RECIP =
        ((64'd1 << CLOCK_W) + 64'(BIT_RATE_HZ) - 64'd1) / 64'(BIT_RATE_HZ);
    localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
    localparam int unsigned Q_W     = RECIP_W;
    localparam int unsigned BACK_W  = Q_W + RATE_W;
    localparam int unsigned CMP_W   = (BACK_W > CLOCK_W) ? BACK_W : CLOCK_W;

    // Configuration
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned RATE_SEL_W      = 2;
    localparam logic [CLOCK_W-1:0] CLOCK_RST = 32'd72000000;
    localparam logic [RATE_SEL_W-1:0] RATE_DSHOT300 = 2'd0;
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CLOCK = 1'b0,
        CFG_RATE_SELECT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RATE  = 2'd1,
        ST_BAD_CLOCK = 2'd2
    } t_status;

endpackage

`default_nettype wire

// File: hdl/dshot_pulse_width_encoder_core.sv
`default_nettype none

// Path: an item's slots go through the working register, then the output register.
// Pace: SLOTS (18) slots per item on a valid setup, one slot on an error setup;
//   the output register moves one slot per cycle unless the receiver stalls.
// Reset: synchronous, active low; the input is stalled after reset
//   and after every register write while the bit period is worked out again.
module dshot_pulse_width_encoder_core
    import dpwe_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,

    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [FRAME_BITS-1:0] i_frame_lane0,
    input  wire [FRAME_BITS-1:0] i_frame_lane1,
    input  wire [FRAME_BITS-1:0] i_frame_lane2,
    input  wire [FRAME_BITS-1:0] i_frame_lane3,

    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [DUTY_W-1:0]    o_duty_lane0,
    output logic [DUTY_W-1:0]    o_duty_lane1,
    output logic [DUTY_W-1:0]    o_duty_lane2,
    output logic [DUTY_W-1:0]    o_duty_lane3,
    output logic [DUTY_W-1:0]    o_bit_period,
    output logic [1:0]           o_status,
    output logic                 o_last
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [CLOCK_W-1:0]    r_clock_hz;
    logic [RATE_SEL_W-1:0] r_rate_sel;
    logic [1:0]            r_cfg_wait;
    logic                  w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_RST;
            r_rate_sel <= RATE_DSHOT300;
            r_cfg_wait <= CFG_SETTLE;
        end else begin
            if (w_cfg_write) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TIMER_CLOCK: r_clock_hz <= CLOCK_W'(i_cfg_data);
                    CFG_RATE_SELECT: r_rate_sel <= RATE_SEL_W'(i_cfg_data);
                    default: ;
                endcase
                r_cfg_wait <= CFG_SETTLE;
            end else if (r_cfg_wait != 2'd0) begin
                r_cfg_wait <= r_cfg_wait - 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bit period, two stages behind the registers.
    // Stage 1: quotient estimate by multiplying with the scaled reciprocal.
    // Stage 2: multiply back and compare; the clock is valid only when the
    // estimate times the rate gives the clock back exactly.
    // ------------------------------------------------------------------
    logic [CLOCK_W+RECIP_W-1:0] w_q_prod;
    logic [Q_W-1:0]             r_q_est;
    logic [CMP_W-1:0]           w_back;
    logic                       w_clock_ok;
    logic [DUTY_W-1:0]          w_eighth;
    t_status                    r_status;
    logic [DUTY_W-1:0]          r_period;
    logic [DUTY_W-1:0]          r_zero_ticks;
    logic [DUTY_W-1:0]          r_one_ticks;

    assign w_q_prod = (CLOCK_W+RECIP_W)'(r_clock_hz) * (CLOCK_W+RECIP_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        r_q_est <= w_q_prod[CLOCK_W +: Q_W];
    end

    always_comb begin
        w_back     = CMP_W'(r_q_est) * CMP_W'(BIT_RATE_HZ);
        // Zero clock gives a zero quotient; period must fit and divide by 8
        w_clock_ok = (w_back == CMP_W'(r_clock_hz))
                  && (r_q_est != '0)
                  && (32'(r_q_est) <= PERIOD_MAX)
                  && (r_q_est[DEN_SHIFT-1:0] == '0);
        w_eighth   = DUTY_W'(r_q_est >> DEN_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        // Rate check wins over the clock check
        if (r_rate_sel != RATE_DSHOT300) begin
            r_status     <= ST_BAD_RATE;
            r_period     <= '0;
            r_zero_ticks <= '0;
            r_one_ticks  <= '0;
        end else if (!w_clock_ok) begin
            r_status     <= ST_BAD_CLOCK;
            r_period     <= '0;
            r_zero_ticks <= '0;
            r_one_ticks  <= '0;
        end else begin
            r_status     <= ST_OK;
            r_period     <= DUTY_W'(r_q_est);
            r_zero_ticks <= DUTY_W'(32'(w_eighth) * ZERO_NUM);
            r_one_ticks  <= DUTY_W'(32'(w_eighth) * ONE_NUM);
        end
    end

    // ------------------------------------------------------------------
    // Slot sequencer. The working register holds the frames of the item in
    // progress, shifted left one bit per slot so the current bit is the MSB.
    // A new item is taken in the same cycle the last slot of the previous
    // one moves into the output register.
    // ------------------------------------------------------------------
    logic [FRAME_BITS-1:0] r_frame [NUM_PORT_LANES];
    logic [FRAME_BITS-1:0] w_frame_in [NUM_PORT_LANES];
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_busy;
    logic                  w_out_free;
    logic                  w_emit;
    logic                  w_item_last;
    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_pad;
    logic [DUTY_W-1:0]     w_duty [NUM_PORT_LANES];

    always_comb begin
        w_frame_in[0] = i_frame_lane0;
        w_frame_in[1] = i_frame_lane1;
        w_frame_in[2] = i_frame_lane2;
        w_frame_in[3] = i_frame_lane3;

        w_out_free  = !o_valid || !i_stall;
        w_emit      = r_busy && w_out_free;
        // An error setup gives one result only
        w_item_last = (r_status != ST_OK) || (32'(r_slot) == SLOTS - 1);
        w_in_ready  = (r_cfg_wait == 2'd0) && (!r_busy || (w_emit && w_item_last));
        w_accept    = i_valid && w_in_ready;
        w_pad       = 32'(r_slot) >= FRAME_BITS;

        for (int l = 0; l < NUM_PORT_LANES; l++) begin
            if (l >= LANES || w_pad) begin
                w_duty[l] = '0;
            end else if (r_frame[l][FRAME_BITS-1]) begin
                w_duty[l] = r_one_ticks;
            end else begin
                w_duty[l] = r_zero_ticks;
            end
        end
    end

    assign o_stall = !w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_emit && w_item_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot <= '0;
            for (int l = 0; l < NUM_PORT_LANES; l++) begin
                r_frame[l] <= w_frame_in[l];
            end
        end else if (w_emit) begin
            // Advance one slot
            r_slot <= r_slot + SLOT_W'(1);
            for (int l = 0; l < NUM_PORT_LANES; l++) begin
                r_frame[l] <= r_frame[l] << 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. Hold while stalled, load a slot when free.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_free) begin
            o_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_duty_lane0 <= w_duty[0];
            o_duty_lane1 <= w_duty[1];
            o_duty_lane2 <= w_duty[2];
            o_duty_lane3 <= w_duty[3];
            o_bit_period <= r_period;
            o_status     <= r_status;
            o_last       <= w_item_last;
        end
    end

endmodule

`default_nettype wire

// File: dv/dshot_pulse_width_encoder_core_tb.sv
`timescale 1ns / 1ps

module dshot_pulse_width_encoder_core_tb;
    import dpwe_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
    localparam int unsigned ITEM_TARGET    = 470;
    localparam int unsigned HOLD_CYCLES    = 400;

    // One queued frame set; a pause entry makes the sender wait until every
    // slot already owed has come out.
    typedef struct packed {
        logic                  pause;
        logic [3:0][15:0]      frames;
    } t_frame_set;

    // One expected output slot.
    typedef struct packed {
        logic [3:0][DUTY_W-1:0] duty;
        logic [DUTY_W-1:0]      period;
        t_status                status;
        logic                   last;
    } t_slot;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_TIMER_CLOCK;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic [FRAME_BITS-1:0] i_frame_lane0 = '0;
    logic [FRAME_BITS-1:0] i_frame_lane1 = '0;
    logic [FRAME_BITS-1:0] i_frame_lane2 = '0;
    logic [FRAME_BITS-1:0] i_frame_lane3 = '0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [DUTY_W-1:0]     o_duty_lane0;
    logic [DUTY_W-1:0]     o_duty_lane1;
    logic [DUTY_W-1:0]     o_duty_lane2;
    logic [DUTY_W-1:0]     o_duty_lane3;
    logic [DUTY_W-1:0]     o_bit_period;
    logic [1:0]            o_status;
    logic                  o_last;

    dshot_pulse_width_encoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frame_lane0 (i_frame_lane0),
        .i_frame_lane1 (i_frame_lane1),
        .i_frame_lane2 (i_frame_lane2),
        .i_frame_lane3 (i_frame_lane3),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_duty_lane0  (o_duty_lane0),
        .o_duty_lane1  (o_duty_lane1),
        .o_duty_lane2  (o_duty_lane2),
        .o_duty_lane3  (o_duty_lane3),
        .o_bit_period  (o_bit_period),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_frame_set frame_q[$];
    t_slot      slot_q[$];

    // Shadow of the configuration registers, updated on each accepted write
    logic [CLOCK_W-1:0]    timer_hz = CLOCK_RST;
    logic [RATE_SEL_W-1:0] rate_sel = RATE_DSHOT300;

    // Handshakes seen at the last rising edge
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    logic cfg_fire = 1'b0;

    // Idle control: idle_on enables random gaps on both sides; hold_cnt forces
    // a long receiver hold-off and runs down in its own process.
    logic idle_on  = 1'b1;
    int unsigned hold_cnt = 0;
    int unsigned gap_left = 0;
    int unsigned rx_wait  = 0;

    int unsigned n_queued  = 0;
    int unsigned n_sets    = 0;
    int unsigned n_slots   = 0;
    int unsigned n_err_out = 0;
    int unsigned n_writes  = 0;
    int unsigned n_fail    = 0;

    // Predict the slots of one frame set from the current register shadow.
    function automatic void encode_frames(logic [3:0][15:0] frames);
        t_slot       s;
        t_status     st;
        logic [31:0] period;
        logic [31:0] unit;
        st     = ST_OK;
        period = '0;
        // Rate choice is checked ahead of the clock.
        if (rate_sel != RATE_DSHOT300) begin
            st = ST_BAD_RATE;
        end else if (timer_hz == 0 || (timer_hz % BIT_RATE_HZ) != 0) begin
            st = ST_BAD_CLOCK;
        end else begin
            period = timer_hz / BIT_RATE_HZ;
            if (period > PERIOD_MAX || (period % DUTY_DEN) != 0) begin
                st     = ST_BAD_CLOCK;
                period = '0;
            end
        end
        if (st != ST_OK) begin
            // Error setup: one slot, everything zero but status and last.
            s.duty   = '0;
            s.period = '0;
            s.status = st;
            s.last   = 1'b1;
            slot_q.push_back(s);
            return;
        end
        unit = period / DUTY_DEN;
        for (int slot = 0; slot < SLOTS; slot++) begin
            for (int lane = 0; lane < 4; lane++) begin
                s.duty[lane] = '0;
                // Frame bits go out MSB first; padding and unused lanes stay zero.
                if (lane < LANES && slot < FRAME_BITS) begin
                    s.duty[lane] = frames[lane][FRAME_BITS-1-slot] ?
                                   DUTY_W'(unit * ONE_NUM) : DUTY_W'(unit * ZERO_NUM);
                end
            end
            s.period = DUTY_W'(period);
            s.status = ST_OK;
            s.last   = (slot == SLOTS - 1);
            slot_q.push_back(s);
        end
    endfunction

    function automatic void flag_error(string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    // Monitor: sample all handshakes on the rising edge, predict on accepted
    // items, check each accepted slot against the oldest expectation.
    always @(posedge i_clk) begin
        t_slot e;
        in_fire  <= i_rst_n && i_valid && !o_stall;
        out_fire <= i_rst_n && o_valid && !i_stall;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_writes++;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TIMER_CLOCK: timer_hz = i_cfg_data;
                    CFG_RATE_SELECT: rate_sel = i_cfg_data[RATE_SEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                n_sets++;
                encode_frames({i_frame_lane3, i_frame_lane2, i_frame_lane1, i_frame_lane0});
            end
            if (o_valid && !i_stall) begin
                n_slots++;
                if (slot_q.size() == 0) begin
                    flag_error($sformatf(
                        "unexpected slot: duty %h %h %h %h per %0d st %0d last %0b",
                        o_duty_lane0, o_duty_lane1, o_duty_lane2, o_duty_lane3,
                        o_bit_period, o_status, o_last));
                end else begin
                    e = slot_q.pop_front();
                    if (e.status != ST_OK) begin
                        n_err_out++;
                    end
                    if (o_duty_lane0 !== e.duty[0] || o_duty_lane1 !== e.duty[1] ||
                        o_duty_lane2 !== e.duty[2] || o_duty_lane3 !== e.duty[3] ||
                        o_bit_period !== e.period || o_status !== e.status ||
                        o_last !== e.last) begin
                        flag_error({
                            $sformatf("exp duty %h %h %h %h per %0d st %0d last %0b",
                                e.duty[0], e.duty[1], e.duty[2], e.duty[3],
                                e.period, e.status, e.last),
                            $sformatf(", got %h %h %h %h per %0d st %0d last %0b",
                                o_duty_lane0, o_duty_lane1, o_duty_lane2, o_duty_lane3,
                                o_bit_period, o_status, o_last)});
                    end
                end
            end
        end
    end

    // Driver: present the next frame set on the falling edge, hold it while
    // stalled, insert a random gap after each accepted item.
    always @(negedge i_clk) begin
        t_frame_set f;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || in_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (frame_q.size() != 0 && frame_q[0].pause) begin
                // Hold off until every owed slot has come out, then drop the marker.
                i_valid <= 1'b0;
                if (slot_q.size() == 0) begin
                    void'(frame_q.pop_front());
                end
            end else if (frame_q.size() != 0) begin
                f = frame_q.pop_front();
                i_valid       <= 1'b1;
                i_frame_lane0 <= f.frames[0];
                i_frame_lane1 <= f.frames[1];
                i_frame_lane2 <= f.frames[2];
                i_frame_lane3 <= f.frames[3];
                gap_left      <= idle_on ? $urandom_range(0, 15) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Run down the long hold-off.
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Receiver: stall through the hold-off; else after each accepted slot, a random stall.
    always @(negedge i_clk) begin
        int unsigned w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else if (hold_cnt != 0) begin
            i_stall <= 1'b1;
        end else if (out_fire) begin
            w = idle_on ? $urandom_range(0, 15) : 0;
            rx_wait <= w;
            i_stall <= (w != 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= (rx_wait > 1);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic queue_frames(logic [15:0] f0, logic [15:0] f1,
                                logic [15:0] f2, logic [15:0] f3);
        t_frame_set f;
        f.pause  = 1'b0;
        f.frames = {f3, f2, f1, f0};
        frame_q.push_back(f);
        n_queued++;
    endtask

    task automatic queue_pause();
        t_frame_set f;
        f.pause  = 1'b1;
        f.frames = '0;
        frame_q.push_back(f);
    endtask

    function automatic logic [15:0] draw_frame();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 16'h0000;
        end
        if (pick == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic queue_random();
        queue_frames(draw_frame(), draw_frame(), draw_frame(), draw_frame());
    endtask

    // Wait until everything queued has been accepted and every owed slot seen,
    // then let the pipeline settle before touching the registers.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (frame_q.size() != 0 || i_valid || slot_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
        end while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(logic [CLOCK_W-1:0] hz, logic [RATE_SEL_W-1:0] sel);
        write_reg(CFG_TIMER_CLOCK, hz);
        write_reg(CFG_RATE_SELECT, CFG_DATA_W'(sel));
    endtask

    // Random phase; sometimes the sender pauses midway until the block drains.
    task automatic run_random(int unsigned n);
        idle_on = ($urandom_range(0, 3) != 0);
        for (int unsigned k = 0; k < n; k++) begin
            if (k == n / 2 && $urandom_range(0, 2) == 0) begin
                queue_pause();
            end
            queue_random();
        end
        wait_drained();
    endtask

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [CLOCK_W-1:0] hz;
        logic [RATE_SEL_W-1:0] sel;
        logic [CLOCK_W-1:0] bad_hz [5];
        int unsigned pick;
        int unsigned n_run;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset setup (72 MHz, DShot300, period 240).
        idle_on = 1'b1;
        queue_frames(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_frames(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_frames(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE);
        queue_frames(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_frames(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        queue_frames(16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00);
        for (int b = 0; b < 16; b += 2) begin
            queue_frames(16'h1 << b, 16'h1 << (b + 1), ~(16'h1 << b), ~(16'h1 << (b + 1)));
        end
        wait_drained();

        // Long receiver hold-off with the sender pushing back to back; the
        // block fills up and must stall its input. Then a sender pause.
        idle_on = 1'b0;
        @(posedge i_clk);
        hold_cnt <= HOLD_CYCLES;
        repeat (24) queue_random();
        queue_pause();
        repeat (6) queue_random();
        wait_drained();

        // Shortest legal period (8 ticks) and the longest one in 32 bits.
        set_timing(32'd2_400_000, RATE_DSHOT300);
        run_random(40);
        set_timing(32'd4_293_600_000, RATE_DSHOT300);
        run_random(40);

        // Bad clocks: zero, not a multiple of the rate, period not a multiple of 8.
        bad_hz[0] = 32'd0;
        bad_hz[1] = 32'hFFFF_FFFF;
        bad_hz[2] = 32'd2_700_000;
        bad_hz[3] = 32'd72_000_001;
        bad_hz[4] = 32'd3_600_000;
        foreach (bad_hz[k]) begin
            set_timing(bad_hz[k], RATE_DSHOT300);
            run_random(6);
        end

        // Unsupported rates, one with a bad clock too so the rate check wins.
        for (int r = 1; r < 4; r++) begin
            set_timing(CLOCK_RST, RATE_SEL_W'(r));
            run_random(6);
        end
        set_timing(32'd0, RATE_SEL_W'(2));
        run_random(4);

        // Random setups, mostly legal periods.
        while (n_queued < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            sel  = RATE_DSHOT300;
            if (pick < 6) begin
                hz = CLOCK_W'(64'(DUTY_DEN * $urandom_range(1, 1789)) * BIT_RATE_HZ);
            end else if (pick < 8) begin
                hz = CLOCK_W'(64'($urandom_range(1, 14316)) * BIT_RATE_HZ);
            end else begin
                hz = $urandom();
                if (pick == 9) begin
                    sel = RATE_SEL_W'($urandom_range(1, 3));
                end
            end
            set_timing(hz, sel);
            n_run = $urandom_range(20, 60);
            if (n_run > ITEM_TARGET - n_queued) begin
                n_run = ITEM_TARGET - n_queued;
            end
            run_random(n_run);
        end

        // Everything accepted and drained; then wait idle for any stray slots.
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (slot_q.size() != 0) begin
            flag_error($sformatf("%0d slots never came out", slot_q.size()));
        end

        $display(
            "Covered %0d frame sets over %0d register writes; %0d slots checked, %0d errors.",
            n_sets, n_writes, n_slots, n_err_out);
        $display("Mismatches: %0d", n_fail);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
